FILE: rtl/dpss_pkg.sv
// ----------------------------------------------------------------------------
// dpss_pkg
// Shared types and constants of the drive power state sequencer: state codes,
// request codes, outcome codes, control word bit masks and the structs that
// carry kept state and step results between modules.
// ----------------------------------------------------------------------------
package dpss_pkg;

  localparam int unsigned CW_W    = 16;
  localparam int unsigned DST_W   = 4;
  localparam int unsigned LIMIT_W = 3;

  // decoded drive power states
  localparam logic [DST_W-1:0] ST_NOT_READY       = 4'd0;
  localparam logic [DST_W-1:0] ST_SWITCH_DISABLED = 4'd1;
  localparam logic [DST_W-1:0] ST_READY           = 4'd2;
  localparam logic [DST_W-1:0] ST_SWITCHED_ON     = 4'd3;
  localparam logic [DST_W-1:0] ST_OP_ENABLED      = 4'd4;
  localparam logic [DST_W-1:0] ST_QUICK_STOP      = 4'd5;
  localparam logic [DST_W-1:0] ST_FAULT_REACTION  = 4'd6;
  localparam logic [DST_W-1:0] ST_FAULT           = 4'd7;
  localparam logic [DST_W-1:0] ST_UNKNOWN         = 4'd8;
  localparam logic [DST_W-1:0] ST_NONE            = 4'd15;

  // requests
  localparam logic [1:0] OP_ENABLE     = 2'd0;
  localparam logic [1:0] OP_DISABLE    = 2'd1;
  localparam logic [1:0] OP_SHUTDOWN   = 2'd2;
  localparam logic [1:0] OP_QUICK_STOP = 2'd3;

  // outcomes
  localparam logic [1:0] OUT_BUSY = 2'd0;
  localparam logic [1:0] OUT_DONE = 2'd1;
  localparam logic [1:0] OUT_FAIL = 2'd2;

  // control word masks
  localparam logic [CW_W-1:0] CW_NONE   = 16'h0000;
  localparam logic [CW_W-1:0] CW_H02    = 16'h0002;
  localparam logic [CW_W-1:0] CW_H04    = 16'h0004;
  localparam logic [CW_W-1:0] CW_H06    = 16'h0006;
  localparam logic [CW_W-1:0] CW_H07    = 16'h0007;
  localparam logic [CW_W-1:0] CW_H0F    = 16'h000F;
  localparam logic [CW_W-1:0] CW_H80    = 16'h0080;
  localparam logic [CW_W-1:0] CW_H81    = 16'h0081;
  localparam logic [CW_W-1:0] CW_H82    = 16'h0082;
  localparam logic [CW_W-1:0] CW_H84    = 16'h0084;
  localparam logic [CW_W-1:0] CW_H88    = 16'h0088;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 3'd2;

  // configuration register map
  localparam int unsigned      PADDR_W         = 3;
  localparam logic             REG_IDX_LIMIT   = 1'b0;

  typedef struct packed {
    logic [CW_W-1:0]    control_copy;
    logic [DST_W-1:0]   previous_state;
    logic [LIMIT_W-1:0] fault_retries;
    logic               check_pending;
  } dpss_state_t;

  typedef struct packed {
    dpss_state_t      state_next;
    logic [CW_W-1:0]  word0;
    logic [CW_W-1:0]  word1;
    logic [1:0]       nwr;
    logic [DST_W-1:0] device_state;
    logic [1:0]       outcome;
  } dpss_step_t;

endpackage

FILE: rtl/drive_power_state_sequencer.sv
// ----------------------------------------------------------------------------
// drive_power_state_sequencer
// Drives a servo drive through its power states: decodes each sampled status
// word against the pending request and emits control word writes.
// Inputs are registered, then each item's results load the result register.
// Throughput: one item per cycle while m_tready holds and it makes at most
// one write; a two-write item holds the result register until both are sent.
// Reset: control copy cleared, no state seen, retries and check cleared,
// fault_retry_limit back to 2, no result pending.
// ----------------------------------------------------------------------------
module drive_power_state_sequencer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [15:0]                    s_tdata,  // status_word[15:0]
  input  logic [2:0]                     s_tuser,  // op[1:0], start_req[2]
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [23:0]                    m_tdata,  // control_word[15:0], device_state[19:16]
  output logic [2:0]                     m_tuser,  // write_valid[0], outcome[2:1]
  output logic                           m_tlast,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [dpss_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import dpss_pkg::*;

  logic               in_valid;
  logic [1:0]         in_op;
  logic               in_start;
  logic [15:0]        in_status;
  logic               fire;
  logic               free;
  logic [LIMIT_W-1:0] fault_retry_limit;
  dpss_state_t        state;
  dpss_step_t         step;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fault_retry_limit <= LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_IDX_LIMIT) begin
      fault_retry_limit <= pwdata[LIMIT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_IDX_LIMIT) ? {29'b0, fault_retry_limit} : 32'b0;

  assign fire     = in_valid && free;
  assign s_tready = !in_valid || free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_op     <= s_tuser[1:0];
      in_start  <= s_tuser[2];
      in_status <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.control_copy   <= '0;
      state.previous_state <= ST_NONE;
      state.fault_retries  <= '0;
      state.check_pending  <= 1'b0;
    end else if (fire) begin
      state <= step.state_next;
    end
  end

  dpss_step u_step (
    .state             (state),
    .fault_retry_limit (fault_retry_limit),
    .op                (in_op),
    .start_req         (in_start),
    .status_word       (in_status),
    .step              (step)
  );

  dpss_outbuf u_outbuf (
    .clk      (clk),
    .rst      (rst),
    .load     (fire),
    .step     (step),
    .free     (free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  a_two_writes: assert property (@(posedge clk) disable iff (rst)
    fire && step.nwr == 2'd2 |=> m_tvalid && !m_tlast && m_tuser[0])
    else $error("two-write item not queued as a pair");

  a_copy_hold: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(state.control_copy))
    else $error("control copy changed without an item");

  a_pending_src: assert property (@(posedge clk) disable iff (rst)
    fire && step.state_next.check_pending |-> in_op == OP_DISABLE || in_op == OP_QUICK_STOP)
    else $error("check armed by enable or shutdown");

  a_last_word: assert property (@(posedge clk) disable iff (rst)
    fire && step.nwr != 2'd0 |=> !$isunknown(m_tdata[15:0]) &&
      (m_tlast ? m_tdata[15:0] == state.control_copy : 1'b1))
    else $error("last write differs from kept control copy");

  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !free)
    else $error("new item loaded over a queued write");

endmodule

FILE: rtl/dpss_step.sv
// ----------------------------------------------------------------------------
// dpss_step
// Status decode and request rules for one item: computes the next kept state,
// up to two control word writes, the decoded state and the outcome.
// ----------------------------------------------------------------------------
module dpss_step (
  input  dpss_pkg::dpss_state_t          state,
  input  logic [dpss_pkg::LIMIT_W-1:0]   fault_retry_limit,
  input  logic [1:0]                     op,
  input  logic                           start_req,
  input  logic [15:0]                    status_word,
  output dpss_pkg::dpss_step_t           step
);
  import dpss_pkg::*;

  logic [DST_W-1:0] st;
  logic [3:0]       low;
  logic             b5;
  logic             b6;
  dpss_state_t      cs;
  logic [CW_W-1:0]  set0;
  logic [CW_W-1:0]  clr0;
  logic [CW_W-1:0]  set1;
  logic [CW_W-1:0]  clr1;
  logic [CW_W-1:0]  w0;
  logic [CW_W-1:0]  w1;
  logic [1:0]       nwr;
  logic [1:0]       outcome;

  assign low = status_word[3:0];
  assign b5  = status_word[5];
  assign b6  = status_word[6];

  always_comb begin
    if (low == 4'h0) begin
      st = b6 ? ST_SWITCH_DISABLED : ST_NOT_READY;
    end else if (b6) begin
      st = ST_UNKNOWN;
    end else if (low == 4'h1 && b5) begin
      st = ST_READY;
    end else if (low == 4'h3 && b5) begin
      st = ST_SWITCHED_ON;
    end else if (low == 4'h7) begin
      st = b5 ? ST_OP_ENABLED : ST_QUICK_STOP;
    end else if (low == 4'hF) begin
      st = ST_FAULT_REACTION;
    end else if (low == 4'h8) begin
      st = ST_FAULT;
    end else begin
      st = ST_UNKNOWN;
    end
  end

  always_comb begin
    cs      = state;
    nwr     = 2'd0;
    set0    = CW_NONE;
    clr0    = CW_NONE;
    set1    = CW_NONE;
    clr1    = CW_NONE;
    outcome = OUT_BUSY;
    if (start_req) begin
      cs.previous_state = ST_NONE;
      cs.fault_retries  = '0;
      cs.check_pending  = 1'b0;
    end

    if ((op == OP_DISABLE || op == OP_QUICK_STOP) && cs.check_pending) begin
      cs.check_pending = 1'b0;
      outcome = (st == ST_UNKNOWN || st == ST_OP_ENABLED) ? OUT_FAIL : OUT_DONE;
    end else if (op == OP_ENABLE) begin
      cs.check_pending = 1'b0;
      if (st == ST_UNKNOWN) begin
        outcome = OUT_FAIL;
      end else if (st == cs.previous_state) begin
        outcome = OUT_DONE;
      end else begin
        cs.previous_state = st;
        case (st)
          ST_NOT_READY: begin
            outcome = OUT_FAIL;
          end
          ST_SWITCH_DISABLED: begin
            nwr  = 2'd1;
            set0 = CW_H06;
            clr0 = CW_H81;
          end
          ST_READY: begin
            nwr  = 2'd1;
            set0 = CW_H07;
            clr0 = CW_H88;
          end
          ST_SWITCHED_ON: begin
            nwr  = 2'd1;
            set0 = CW_H0F;
            clr0 = CW_H80;
          end
          ST_QUICK_STOP: begin
            nwr  = 2'd2;
            clr0 = CW_H04;
            set1 = CW_H0F;
            clr1 = CW_H80;
          end
          ST_FAULT: begin
            if (cs.fault_retries >= fault_retry_limit) begin
              nwr     = 2'd2;
              clr0    = CW_H80;
              set1    = CW_H80;
              outcome = OUT_FAIL;
            end else begin
              cs.fault_retries = cs.fault_retries + 3'd1;
            end
          end
          default: begin
          end
        endcase
      end
    end else if (op == OP_DISABLE) begin
      if (st == ST_UNKNOWN || st == ST_NOT_READY) begin
        outcome = OUT_FAIL;
      end else begin
        if (st == ST_FAULT) begin
          nwr  = 2'd2;
          clr0 = CW_H80;
          set1 = CW_H80;
        end else if (st == ST_OP_ENABLED) begin
          nwr  = 2'd1;
          set0 = CW_H07;
          clr0 = CW_H88;
        end
        cs.check_pending = 1'b1;
      end
    end else if (op == OP_SHUTDOWN) begin
      cs.check_pending = 1'b0;
      if (st == ST_UNKNOWN || st == ST_NOT_READY) begin
        outcome = OUT_FAIL;
      end else begin
        if (st == ST_FAULT) begin
          nwr  = 2'd2;
          clr0 = CW_H80;
          set1 = CW_H80;
        end else if (st == ST_QUICK_STOP) begin
          nwr  = 2'd1;
          clr0 = CW_H82;
        end else if (st == ST_OP_ENABLED || st == ST_SWITCHED_ON ||
                     st == ST_SWITCH_DISABLED) begin
          nwr  = 2'd1;
          set0 = CW_H06;
          clr0 = CW_H81;
        end
        outcome = OUT_DONE;
      end
    end else begin
      if (st == ST_UNKNOWN) begin
        outcome = OUT_FAIL;
      end else begin
        if (st == ST_OP_ENABLED) begin
          nwr  = 2'd1;
          set0 = CW_H02;
          clr0 = CW_H84;
        end
        cs.check_pending = 1'b1;
      end
    end
  end

  assign w0 = (state.control_copy | set0) & ~clr0;
  assign w1 = (w0 | set1) & ~clr1;

  always_comb begin
    step.state_next = cs;
    case (nwr)
      2'd1:    step.state_next.control_copy = w0;
      2'd2:    step.state_next.control_copy = w1;
      default: step.state_next.control_copy = state.control_copy;
    endcase
    step.word0        = (nwr == 2'd0) ? state.control_copy : w0;
    step.word1        = w1;
    step.nwr          = nwr;
    step.device_state = st;
    step.outcome      = outcome;
  end

endmodule

FILE: rtl/dpss_outbuf.sv
// ----------------------------------------------------------------------------
// dpss_outbuf
// Result register: holds the results of one item and hands them out one per
// transfer, the second write queued behind the first.
// ----------------------------------------------------------------------------
module dpss_outbuf (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  dpss_pkg::dpss_step_t  step,
  output logic                  free,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [23:0]           m_tdata,  // control_word[15:0], device_state[19:16]
  output logic [2:0]            m_tuser,  // write_valid[0], outcome[2:1]
  output logic                  m_tlast
);
  import dpss_pkg::*;

  logic             out_valid;
  logic             second;
  logic [CW_W-1:0]  cur_word;
  logic [CW_W-1:0]  next_word;
  logic             wr_valid;
  logic [DST_W-1:0] dev_state;
  logic [1:0]       outcome;

  assign free = !out_valid || (m_tready && !second);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      second    <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
      second    <= (step.nwr == 2'd2);
    end else if (out_valid && m_tready) begin
      if (second) begin
        second <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_word  <= step.word0;
      next_word <= step.word1;
      wr_valid  <= (step.nwr != 2'd0);
      dev_state <= step.device_state;
      outcome   <= step.outcome;
    end else if (out_valid && m_tready && second) begin
      cur_word <= next_word;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0, dev_state, cur_word};
  assign m_tuser  = {outcome, wr_valid};
  assign m_tlast  = !second;

endmodule
